// ===== rtl/rgb_to_hls_converter_unit_assert.svh =====
// ----------------------------------------------------------------------------
// rgb_to_hls_converter_unit_assert: assertion macros
// clocked property checks that compile away in synthesis
// ----------------------------------------------------------------------------
`ifndef RGB_TO_HLS_CONVERTER_UNIT_ASSERT_SVH
`define RGB_TO_HLS_CONVERTER_UNIT_ASSERT_SVH

`ifndef SYNTHESIS

// combinational property sampled on the clock, off during reset
`define RGBHLS_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// implication whose consequent is checked in the next cycle
`define RGBHLS_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`else

`define RGBHLS_ASSERT(label, clk, rst, prop, msg)
`define RGBHLS_ASSERT_NEXT(label, clk, rst, ante, cons, msg)

`endif

`endif

// ===== rtl/rgbhls_pkg.sv =====
// ----------------------------------------------------------------------------
// rgbhls_pkg: shared types and constants
// hue sector codes and fixed field widths of the rgb to hls converter
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package rgbhls_pkg;

   // width of the hue result field
   localparam int HUE_W = 15;

   // which channel holds the maximum, picks the hue sector
   typedef enum logic [1:0] {
      HSEL_RED   = 2'b00,
      HSEL_GREEN = 2'b01,
      HSEL_BLUE  = 2'b10
   } hue_sel_type;

endpackage

`default_nettype wire

// ===== rtl/rgbhls_div_pipe.sv =====
// ----------------------------------------------------------------------------
// rgbhls_div_pipe: pipelined restoring divider
// one quotient bit per register stage, side payload travels with the word
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module rgbhls_div_pipe #(
   parameter int DEN_W = 16,
   parameter int QUO_W = 16,
   parameter int PAY_W = 1,
   localparam int NUM_W = DEN_W + QUO_W
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             advance,
   input  wire logic             in_valid,
   input  wire logic [NUM_W-1:0] in_num,
   input  wire logic [DEN_W-1:0] in_den,
   input  wire logic [PAY_W-1:0] in_pay,
   output logic                  out_valid,
   output logic [QUO_W-1:0]      out_quo,
   output logic [PAY_W-1:0]      out_pay
);

   // numerator must stay below den * 2^QUO_W
   logic             vld_ff [QUO_W];
   logic [NUM_W-1:0] rem_ff [QUO_W-1];
   logic [DEN_W-1:0] den_ff [QUO_W];
   logic [QUO_W-1:0] quo_ff [QUO_W];
   logic [PAY_W-1:0] pay_ff [QUO_W];

   for (genvar i = 0; i < QUO_W; i++) begin : g_stage
      localparam int BIT = QUO_W - 1 - i;

      logic             src_vld;
      logic [NUM_W-1:0] src_rem;
      logic [DEN_W-1:0] src_den;
      logic [QUO_W-1:0] src_quo;
      logic [PAY_W-1:0] src_pay;
      logic [NUM_W-1:0] trial;
      logic             rem_ge;

      if (i == 0) begin : g_first
         assign src_vld = in_valid;
         assign src_rem = in_num;
         assign src_den = in_den;
         assign src_quo = '0;
         assign src_pay = in_pay;
      end else begin : g_next
         assign src_vld = vld_ff[i-1];
         assign src_rem = rem_ff[i-1];
         assign src_den = den_ff[i-1];
         assign src_quo = quo_ff[i-1];
         assign src_pay = pay_ff[i-1];
      end

      assign trial  = NUM_W'(src_den) << BIT;
      assign rem_ge = (src_rem >= trial);

      always_ff @(posedge clock) begin
         if (reset) begin
            vld_ff[i] <= 1'b0;
         end else if (advance) begin
            vld_ff[i] <= src_vld;
         end
      end

      always_ff @(posedge clock) begin
         if (advance) begin
            den_ff[i] <= src_den;
            quo_ff[i] <= rem_ge ? (src_quo | (QUO_W'(1) << BIT)) : src_quo;
            pay_ff[i] <= src_pay;
         end
      end

      // the last stage keeps no remainder, only the quotient and its side data
      if (i < QUO_W - 1) begin : g_rem
         logic [NUM_W-1:0] rem_in;

         assign rem_in = rem_ge ? (src_rem - trial) : src_rem;

         always_ff @(posedge clock) begin
            if (advance) begin
               rem_ff[i] <= rem_in;
            end
         end
      end
   end

   assign out_valid = vld_ff[QUO_W-1];
   assign out_quo   = quo_ff[QUO_W-1];
   assign out_pay   = pay_ff[QUO_W-1];

endmodule

`default_nettype wire

// ===== rtl/rgb_to_hls_converter_unit.sv =====
// ----------------------------------------------------------------------------
// rgb_to_hls_converter_unit: pixel rgb to hue / saturation / lightness
// pipeline: the input stages, the divider stages and the output register, with
//   divider width QW = max(CHANNEL_BITS, clog2(60 * 2^HUE_FRAC_BITS + 1))
// throughput: one word per cycle; depth is set by the two restoring dividers,
//   one quotient bit per stage; a blocked result stalls the whole pipeline
// reset: synchronous, clears all valid bits; no state between pixels
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module rgb_to_hls_converter_unit #(
   parameter int CHANNEL_BITS  = 16,
   parameter int HUE_FRAC_BITS = 6
) (
   input  wire logic                       clock,
   input  wire logic                       reset,
   // pixel words in
   input  wire logic                       req_valid,
   output logic                            req_ready,
   input  wire logic [CHANNEL_BITS-1:0]    req_red_in,
   input  wire logic [CHANNEL_BITS-1:0]    req_green_in,
   input  wire logic [CHANNEL_BITS-1:0]    req_blue_in,
   // hls words out
   output logic                            rsp_valid,
   input  wire logic                       rsp_ready,
   output logic [rgbhls_pkg::HUE_W-1:0]    rsp_hue_out,
   output logic [CHANNEL_BITS-1:0]         rsp_sat_out,
   output logic [CHANNEL_BITS-1:0]         rsp_light_out,
   output logic                            rsp_grey_flag
);

`include "rgb_to_hls_converter_unit_assert.svh"

   localparam int CB       = CHANNEL_BITS;
   localparam int STEP     = 1 << HUE_FRAC_BITS;
   // 60 degrees in hue steps, and the quotient width that holds it
   localparam int HUE60    = 60 * STEP;
   localparam int H60_W    = $clog2(HUE60 + 1);
   // common quotient width for both dividers, so they line up in time
   localparam int QW       = (CB > H60_W) ? CB : H60_W;
   localparam int NW       = CB + QW;
   localparam int HUE_SPAN = 360 * STEP;
   localparam int G_BASE   = 120 * STEP;
   localparam int B_BASE   = 240 * STEP;
   localparam int HC_W     = $clog2(HUE_SPAN + 1);
   localparam logic [CB-1:0] FULL     = '1;
   localparam logic [CB:0]   TWO_FULL = {FULL, 1'b0};

   // whole pipeline moves when the output register is free or being drained
   logic advance;

   assign advance   = !rsp_valid || rsp_ready;
   assign req_ready = advance;

   // ---------------------------------------------------------------------
   // stage 1: pick max channel (red wins ties, then green), min, and the
   // signed channel difference that goes into the hue sector
   // ---------------------------------------------------------------------
   rgbhls_pkg::hue_sel_type sel_in;
   logic [CB-1:0]           max_in;
   logic [CB-1:0]           min_in;
   logic [CB:0]             diff_in;

   always_comb begin
      if (req_red_in >= req_green_in && req_red_in >= req_blue_in) begin
         sel_in = rgbhls_pkg::HSEL_RED;
      end else if (req_green_in >= req_blue_in) begin
         sel_in = rgbhls_pkg::HSEL_GREEN;
      end else begin
         sel_in = rgbhls_pkg::HSEL_BLUE;
      end

      min_in = req_red_in;
      if (req_green_in < min_in) begin
         min_in = req_green_in;
      end
      if (req_blue_in < min_in) begin
         min_in = req_blue_in;
      end

      unique case (sel_in)
         rgbhls_pkg::HSEL_RED: begin
            max_in  = req_red_in;
            diff_in = (CB+1)'(req_green_in) - (CB+1)'(req_blue_in);
         end
         rgbhls_pkg::HSEL_GREEN: begin
            max_in  = req_green_in;
            diff_in = (CB+1)'(req_blue_in) - (CB+1)'(req_red_in);
         end
         rgbhls_pkg::HSEL_BLUE: begin
            max_in  = req_blue_in;
            diff_in = (CB+1)'(req_red_in) - (CB+1)'(req_green_in);
         end
         default: begin
            max_in  = req_red_in;
            diff_in = '0;
         end
      endcase
   end

   logic                    s1_vld_ff;
   rgbhls_pkg::hue_sel_type s1_sel_ff;
   logic [CB-1:0]           s1_max_ff;
   logic [CB-1:0]           s1_min_ff;
   logic [CB:0]             s1_diff_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_vld_ff <= 1'b0;
      end else if (advance) begin
         s1_vld_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         s1_sel_ff  <= sel_in;
         s1_max_ff  <= max_in;
         s1_min_ff  <= min_in;
         s1_diff_ff <= diff_in;
      end
   end

   // ---------------------------------------------------------------------
   // stage 2: delta, sum, lightness, saturation denominator, |diff|
   // ---------------------------------------------------------------------
   logic [CB:0]   sum_in;
   logic [CB-1:0] delta_in;
   logic [CB-1:0] absd_in;
   logic [CB-1:0] den_in;
   logic          neg_in;
   logic          grey_in;

   always_comb begin
      sum_in   = (CB+1)'(s1_max_ff) + (CB+1)'(s1_min_ff);
      delta_in = s1_max_ff - s1_min_ff;
      neg_in   = s1_diff_ff[CB];
      absd_in  = neg_in ? CB'(-s1_diff_ff) : CB'(s1_diff_ff);
      grey_in  = (delta_in == '0);
      // lower half uses max+min, upper half uses 2 - max - min
      if (sum_in <= (CB+1)'(FULL)) begin
         den_in = CB'(sum_in);
      end else begin
         den_in = CB'(TWO_FULL - sum_in);
      end
   end

   logic                    s2_vld_ff;
   rgbhls_pkg::hue_sel_type s2_sel_ff;
   logic                    s2_neg_ff;
   logic                    s2_grey_ff;
   logic [CB-1:0]           s2_light_ff;
   logic [CB-1:0]           s2_delta_ff;
   logic [CB-1:0]           s2_absd_ff;
   logic [CB-1:0]           s2_den_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_vld_ff <= 1'b0;
      end else if (advance) begin
         s2_vld_ff <= s1_vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         s2_sel_ff   <= s1_sel_ff;
         s2_neg_ff   <= neg_in;
         s2_grey_ff  <= grey_in;
         s2_light_ff <= sum_in[CB:1];
         s2_delta_ff <= delta_in;
         s2_absd_ff  <= absd_in;
         s2_den_ff   <= den_in;
      end
   end

   // ---------------------------------------------------------------------
   // stage 3: numerators; hue gets 60 degrees times |diff|, saturation gets
   // delta times full scale, done as a shift and subtract
   // ---------------------------------------------------------------------
   logic [NW-1:0] hnum_in;
   logic [NW-1:0] snum_in;

   assign hnum_in = NW'(s2_absd_ff) * NW'(HUE60);
   assign snum_in = (NW'(s2_delta_ff) << CB) - NW'(s2_delta_ff);

   logic                    s3_vld_ff;
   rgbhls_pkg::hue_sel_type s3_sel_ff;
   logic                    s3_neg_ff;
   logic                    s3_grey_ff;
   logic [CB-1:0]           s3_light_ff;
   logic [NW-1:0]           s3_hnum_ff;
   logic [NW-1:0]           s3_snum_ff;
   logic [CB-1:0]           s3_hden_ff;
   logic [CB-1:0]           s3_sden_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s3_vld_ff <= 1'b0;
      end else if (advance) begin
         s3_vld_ff <= s2_vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         s3_sel_ff   <= s2_sel_ff;
         s3_neg_ff   <= s2_neg_ff;
         s3_grey_ff  <= s2_grey_ff;
         s3_light_ff <= s2_light_ff;
         s3_hnum_ff  <= hnum_in;
         s3_snum_ff  <= snum_in;
         s3_hden_ff  <= s2_delta_ff;
         s3_sden_ff  <= s2_den_ff;
      end
   end

   // ---------------------------------------------------------------------
   // dividers: both quotients fit QW bits since |diff| <= delta and
   // delta <= saturation denominator; grey words divide the hue by zero and get
   // their results forced below
   // ---------------------------------------------------------------------
   logic          hdiv_vld;
   logic [QW-1:0] hdiv_quo;
   logic [2:0]    hdiv_pay;
   logic          sdiv_vld;
   logic [QW-1:0] sdiv_quo;
   logic [CB:0]   sdiv_pay;

   rgbhls_div_pipe #(
      .DEN_W (CB),
      .QUO_W (QW),
      .PAY_W (3)
   ) u_hue_div (
      .clock     (clock),
      .reset     (reset),
      .advance   (advance),
      .in_valid  (s3_vld_ff),
      .in_num    (s3_hnum_ff),
      .in_den    (s3_hden_ff),
      .in_pay    ({s3_sel_ff, s3_neg_ff}),
      .out_valid (hdiv_vld),
      .out_quo   (hdiv_quo),
      .out_pay   (hdiv_pay)
   );

   rgbhls_div_pipe #(
      .DEN_W (CB),
      .QUO_W (QW),
      .PAY_W (CB + 1)
   ) u_sat_div (
      .clock     (clock),
      .reset     (reset),
      .advance   (advance),
      .in_valid  (s3_vld_ff),
      .in_num    (s3_snum_ff),
      .in_den    (s3_sden_ff),
      .in_pay    ({s3_grey_ff, s3_light_ff}),
      .out_valid (sdiv_vld),
      .out_quo   (sdiv_quo),
      .out_pay   (sdiv_pay)
   );

   // ---------------------------------------------------------------------
   // final stage: place the hue offset in its sector, wrap negative red hue
   // around 360 degrees, force grey pixels to zero hue and saturation
   // ---------------------------------------------------------------------
   rgbhls_pkg::hue_sel_type fin_sel;
   logic                    fin_neg;
   logic                    fin_grey;
   logic [HC_W-1:0]         qx;
   logic [HC_W-1:0]         hue_calc;
   logic [CB-1:0]           sat_calc;

   assign fin_sel  = rgbhls_pkg::hue_sel_type'(hdiv_pay[2:1]);
   assign fin_neg  = hdiv_pay[0];
   assign fin_grey = sdiv_pay[CB];
   assign qx       = HC_W'(hdiv_quo);

   always_comb begin
      unique case (fin_sel)
         rgbhls_pkg::HSEL_RED: begin
            if (fin_neg && qx != '0) begin
               hue_calc = HC_W'(HUE_SPAN) - qx;
            end else begin
               hue_calc = qx;
            end
         end
         rgbhls_pkg::HSEL_GREEN: begin
            hue_calc = fin_neg ? (HC_W'(G_BASE) - qx) : (HC_W'(G_BASE) + qx);
         end
         rgbhls_pkg::HSEL_BLUE: begin
            hue_calc = fin_neg ? (HC_W'(B_BASE) - qx) : (HC_W'(B_BASE) + qx);
         end
         default: begin
            hue_calc = '0;
         end
      endcase
      sat_calc = CB'(sdiv_quo);
      if (fin_grey) begin
         hue_calc = '0;
         sat_calc = '0;
      end
   end

   // output register
   logic                          rsp_valid_ff;
   logic [rgbhls_pkg::HUE_W-1:0]  rsp_hue_ff;
   logic [CB-1:0]                 rsp_sat_ff;
   logic [CB-1:0]                 rsp_light_ff;
   logic                          rsp_grey_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         rsp_valid_ff <= hdiv_vld;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         rsp_hue_ff   <= rgbhls_pkg::HUE_W'(hue_calc);
         rsp_sat_ff   <= sat_calc;
         rsp_light_ff <= sdiv_pay[CB-1:0];
         rsp_grey_ff  <= fin_grey;
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_hue_out   = rsp_hue_ff;
   assign rsp_sat_out   = rsp_sat_ff;
   assign rsp_light_out = rsp_light_ff;
   assign rsp_grey_flag = rsp_grey_ff;

   // ---------------------------------------------------------------------
   // checks
   // ---------------------------------------------------------------------
   // both dividers carry the same word in lockstep
   `RGBHLS_ASSERT(a_div_lockstep, clock, reset, hdiv_vld == sdiv_vld, "divider valids differ")

   // grey words leave with zero hue and zero saturation
   `RGBHLS_ASSERT(a_grey_zero, clock, reset, !rsp_valid || !rsp_grey_flag || (rsp_hue_out == '0 && rsp_sat_out == '0), "grey word has nonzero hue or saturation")

   // a stall freezes the pipeline front
   `RGBHLS_ASSERT_NEXT(a_stall_hold, clock, reset, !advance, s1_vld_ff == $past(s1_vld_ff) && s3_vld_ff == $past(s3_vld_ff), "pipeline moved during stall")

endmodule

`default_nettype wire

// ===== tb/sv/hls_result_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hls_result_checker: pixel in, hls word out checker
// predicts hue / saturation / lightness / grey for every accepted pixel word
// and compares each accepted result word against the oldest prediction
// ----------------------------------------------------------------------------

module hls_result_checker (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   input  logic                         req_ready,
   input  logic [15:0]                  req_red_in,
   input  logic [15:0]                  req_green_in,
   input  logic [15:0]                  req_blue_in,
   input  logic                         rsp_valid,
   input  logic                         rsp_ready,
   input  logic [rgbhls_pkg::HUE_W-1:0] rsp_hue_out,
   input  logic [15:0]                  rsp_sat_out,
   input  logic [15:0]                  rsp_light_out,
   input  logic                         rsp_grey_flag,
   output int                           fail_count,
   output int                           in_flight
);

   localparam longint FULL_SCALE = 65535;
   localparam longint HUE_STEP   = 64;   // 2^6 hue steps per degree

   typedef struct packed {
      logic [rgbhls_pkg::HUE_W-1:0] hue;
      logic [15:0]                  sat;
      logic [15:0]                  light;
      logic                         grey;
   } hls_word_type;

   hls_word_type pending_hls[$];
   int           errors = 0;

   assign fail_count = errors;

   function automatic hls_word_type predict_hls(logic [15:0] r, logic [15:0] g,
                                                logic [15:0] b);
      longint                  red, grn, blu, mx, mn, delta, sum, hue, sat;
      rgbhls_pkg::hue_sel_type sector;
      hls_word_type            res;
      red = r;
      grn = g;
      blu = b;
      // red wins ties, then green
      sector = rgbhls_pkg::HSEL_RED;
      mx = red;
      if (grn > mx) begin
         mx = grn;
         sector = rgbhls_pkg::HSEL_GREEN;
      end
      if (blu > mx) begin
         mx = blu;
         sector = rgbhls_pkg::HSEL_BLUE;
      end
      mn = red;
      if (grn < mn) mn = grn;
      if (blu < mn) mn = blu;
      delta = mx - mn;
      sum = mx + mn;
      if (delta == 0) begin
         hue = 0;
         sat = 0;
      end else begin
         case (sector)
            rgbhls_pkg::HSEL_RED: begin
               hue = (60 * HUE_STEP * (grn - blu)) / delta;
               if (hue < 0) hue += 360 * HUE_STEP;
            end
            rgbhls_pkg::HSEL_GREEN:
               hue = 120 * HUE_STEP + (60 * HUE_STEP * (blu - red)) / delta;
            default:
               hue = 240 * HUE_STEP + (60 * HUE_STEP * (red - grn)) / delta;
         endcase
         if (sum <= FULL_SCALE) sat = (delta * FULL_SCALE) / sum;
         else sat = (delta * FULL_SCALE) / (2 * FULL_SCALE - sum);
      end
      res.hue = hue[rgbhls_pkg::HUE_W-1:0];
      res.sat = sat[15:0];
      res.light = sum[16:1];
      res.grey = (delta == 0);
      return res;
   endfunction

   function automatic void check_field(string name, longint want, longint got);
      if (want != got) begin
         $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
         errors++;
      end
   endfunction

   always @(posedge clock) begin
      hls_word_type want;
      if (!reset) begin
         if (rsp_valid && rsp_ready) begin
            if (pending_hls.size() == 0) begin
               $display("%0t: result word with no pixel pending, expected none, %s",
                        $time, "actual below");
               $display("%0t: actual %0d %0d %0d %0d",
                        $time, rsp_hue_out, rsp_sat_out, rsp_light_out, rsp_grey_flag);
               errors++;
            end else begin
               want = pending_hls.pop_front();
               check_field("hue", want.hue, rsp_hue_out);
               check_field("saturation", want.sat, rsp_sat_out);
               check_field("lightness", want.light, rsp_light_out);
               check_field("grey flag", want.grey, rsp_grey_flag);
            end
         end
         if (req_valid && req_ready)
            pending_hls.push_back(predict_hls(req_red_in, req_green_in, req_blue_in));
         in_flight <= pending_hls.size();
      end
   end

endmodule

// ===== tb/sv/testbench.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench: rgb to hls converter regression
// drives corner pixels and then random pixel words with idle gaps on both
// channels, long back-pressure holds and a full drain; a checker beside the
// block predicts and compares every result word
// ----------------------------------------------------------------------------

module testbench;

   localparam int RANDOM_WORDS = 1150;
   localparam int CYCLE_LIMIT  = 500000;
   localparam int HOLD_CYCLES  = 250;
   localparam int DRAIN_WAIT   = 40;

   logic                         clock         = 1'b0;
   logic                         reset         = 1'b1;
   logic                         req_valid     = 1'b0;
   logic                         req_ready;
   logic [15:0]                  req_red_in    = '0;
   logic [15:0]                  req_green_in  = '0;
   logic [15:0]                  req_blue_in   = '0;
   logic                         rsp_valid;
   logic                         rsp_ready     = 1'b0;
   logic [rgbhls_pkg::HUE_W-1:0] rsp_hue_out;
   logic [15:0]                  rsp_sat_out;
   logic [15:0]                  rsp_light_out;
   logic                         rsp_grey_flag;

   int               fail_count;
   int               in_flight;
   int               cycles        = 0;
   // set while the sender offers words back to back
   bit               steady        = 1'b0;

   rgb_to_hls_converter_unit u_dut (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req_red_in    (req_red_in),
      .req_green_in  (req_green_in),
      .req_blue_in   (req_blue_in),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .rsp_hue_out   (rsp_hue_out),
      .rsp_sat_out   (rsp_sat_out),
      .rsp_light_out (rsp_light_out),
      .rsp_grey_flag (rsp_grey_flag)
   );

   hls_result_checker u_check (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req_red_in    (req_red_in),
      .req_green_in  (req_green_in),
      .req_blue_in   (req_blue_in),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .rsp_hue_out   (rsp_hue_out),
      .rsp_sat_out   (rsp_sat_out),
      .rsp_light_out (rsp_light_out),
      .rsp_grey_flag (rsp_grey_flag),
      .fail_count    (fail_count),
      .in_flight     (in_flight)
   );

   always #5 clock = ~clock;

   // hard stop in case the block hangs
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles == CYCLE_LIMIT) begin
         $display("Regression FAIL");
         $finish;
      end
   end

   // idle length: mostly none, some short, a few long
   function automatic int idle_gap();
      int unsigned roll;
      roll = $urandom_range(0, 99);
      if (roll < 70) return 0;
      if (roll < 95) return $urandom_range(1, 3);
      return $urandom_range(10, 40);
   endfunction

   // channel values that sit on the edges and the middle of the range, or at random
   function automatic logic [15:0] corner_value();
      case ($urandom_range(0, 6))
         0: return 16'h0000;
         1: return 16'h0001;
         2: return 16'h7FFF;
         3: return 16'h8000;
         4: return 16'hFFFE;
         5: return 16'hFFFF;
         default: return 16'($urandom());
      endcase
   endfunction

   // offer one pixel word and hold it until it is taken; valid stays high
   // after the handshake so the next word can follow with no bubble
   task automatic send_pixel(logic [15:0] r, logic [15:0] g, logic [15:0] b);
      int gap;
      gap = steady ? 0 : idle_gap();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_red_in <= r;
      req_green_in <= g;
      req_blue_in <= b;
      do @(posedge clock); while (!req_ready);
   endtask

   // result side: random stalls, one stall-free stretch and long holds
   // that back the pipeline up into the input
   initial begin : receiver
      int taken;
      int hold_left;
      int stall_left;
      int next_hold_at;
      int unsigned roll;
      taken = 0;
      hold_left = 0;
      stall_left = 0;
      next_hold_at = 300;
      while (reset) @(posedge clock);
      forever begin
         @(posedge clock);
         if (rsp_valid && rsp_ready) taken++;
         if (hold_left > 0) begin
            hold_left--;
            rsp_ready <= 1'b0;
         end else if (taken >= next_hold_at) begin
            // long hold while the sender keeps offering words
            hold_left = HOLD_CYCLES - 1;
            next_hold_at += 600;
            rsp_ready <= 1'b0;
         end else if (taken >= 500 && taken < 700) begin
            rsp_ready <= 1'b1;
         end else if (stall_left > 0) begin
            stall_left--;
            rsp_ready <= 1'b0;
         end else begin
            roll = $urandom_range(0, 99);
            if (roll < 15) begin
               stall_left = (roll < 2) ? $urandom_range(9, 39) : $urandom_range(0, 2);
               rsp_ready <= 1'b0;
            end else begin
               rsp_ready <= 1'b1;
            end
         end
      end
   end

   initial begin : stimulus
      logic [15:0] a, b, c, pr, pg, pb;
      int unsigned n;
      int unsigned hi;
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // black, white and mid grey
      send_pixel(16'h0000, 16'h0000, 16'h0000);
      send_pixel(16'hFFFF, 16'hFFFF, 16'hFFFF);
      send_pixel(16'h8000, 16'h8000, 16'h8000);
      // pure primaries
      send_pixel(16'hFFFF, 16'h0000, 16'h0000);
      send_pixel(16'h0000, 16'hFFFF, 16'h0000);
      send_pixel(16'h0000, 16'h0000, 16'hFFFF);
      // ties for the maximum: red beats green and blue, green beats blue
      send_pixel(16'hFFFF, 16'hFFFF, 16'h0000);
      send_pixel(16'hFFFF, 16'h0000, 16'hFFFF);
      send_pixel(16'h0000, 16'hFFFF, 16'hFFFF);
      send_pixel(16'h4000, 16'h4000, 16'h1000);
      // red max with blue above green wraps hue below 360
      send_pixel(16'hFFFF, 16'h0000, 16'h0001);
      send_pixel(16'h9000, 16'h2000, 16'h8FFF);
      // green and blue sectors, both signs of the difference term
      send_pixel(16'h3000, 16'hC000, 16'h1000);
      send_pixel(16'h1000, 16'hC000, 16'h3000);
      send_pixel(16'h3000, 16'h1000, 16'hC000);
      send_pixel(16'h1000, 16'h3000, 16'hC000);
      // lightness exactly one half, just below and just above
      send_pixel(16'h8000, 16'h7FFF, 16'h7FFF);
      send_pixel(16'hFFFE, 16'h0000, 16'h8000);
      send_pixel(16'hFFFF, 16'h0001, 16'h8000);
      // smallest possible delta at both ends of the range
      send_pixel(16'h0001, 16'h0000, 16'h0000);
      send_pixel(16'hFFFF, 16'hFFFE, 16'hFFFE);
      send_pixel(16'h0000, 16'h0001, 16'h0001);

      // sender pauses until the block has drained completely
      req_valid <= 1'b0;
      do @(posedge clock); while (in_flight != 0);

      for (n = 0; n < RANDOM_WORDS; n++) begin
         steady = (n >= 200 && n < 400);
         case ($urandom_range(0, 9))
            5: begin
               // grey
               a = 16'($urandom());
               b = a;
               c = a;
            end
            6: begin
               // two channels tie for the maximum
               a = 16'($urandom());
               b = a;
               c = 16'($urandom_range(0, a));
            end
            7: begin
               a = corner_value();
               b = corner_value();
               c = corner_value();
            end
            8: begin
               // nearly grey, tiny delta
               a = 16'($urandom_range(0, 65532));
               b = a + 16'($urandom_range(0, 3));
               c = a + 16'($urandom_range(0, 3));
            end
            9: begin
               // max + min around full scale, where the saturation formula switches
               c = 16'($urandom_range(0, 32767));
               hi = 32'hFFFF - c + $urandom_range(0, 2) - 1;
               a = (hi > 32'hFFFF) ? 16'hFFFF : hi[15:0];
               b = 16'($urandom_range(c, a));
            end
            default: begin
               a = 16'($urandom());
               b = 16'($urandom());
               c = 16'($urandom());
            end
         endcase
         // random channel order so every pattern lands in every hue sector
         case ($urandom_range(0, 5))
            0: begin pr = a; pg = b; pb = c; end
            1: begin pr = a; pg = c; pb = b; end
            2: begin pr = b; pg = a; pb = c; end
            3: begin pr = b; pg = c; pb = a; end
            4: begin pr = c; pg = a; pb = b; end
            default: begin pr = c; pg = b; pb = a; end
         endcase
         send_pixel(pr, pg, pb);
      end

      req_valid <= 1'b0;
      do @(posedge clock); while (in_flight != 0);
      repeat (DRAIN_WAIT) @(posedge clock);
      if (fail_count == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end

endmodule
